// ===== design/rrip_pkg.sv =====
// Shared types, constants and helpers of the RRIP replacement block.
package rrip_pkg;

	localparam int SETS          = 2048;
	localparam int WAYS          = 16;
	localparam int PRED_ENTRIES  = 8192;
	localparam int STRIDE_WINDOW = 32;
	localparam int PHASE_LEN     = 64;

	localparam int SET_W  = $clog2(SETS);
	localparam int WAY_W  = $clog2(WAYS);
	localparam int PRED_W = $clog2(PRED_ENTRIES);
	localparam int WIN_W  = $clog2(STRIDE_WINDOW + 1);
	localparam int REG_W  = $clog2(STRIDE_WINDOW);
	localparam int PH_W   = $clog2(PHASE_LEN);
	localparam int HITS_W = $clog2(PHASE_LEN + 1);
	localparam int ADDR_W = 48;
	localparam int TOT_W  = 24;
	localparam int STR_W  = 49;
	localparam int RRPV_W = 2;
	localparam int ROW_W  = WAYS * RRPV_W;
	localparam int LINE_SPAN = 64;

	// clearing pass covers the larger of sets and predictor entries
	localparam int CLR_N = (PRED_ENTRIES > SETS) ? PRED_ENTRIES : SETS;
	localparam int CLR_W = $clog2(CLR_N);

	localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;

	localparam int META_W = ADDR_W + TOT_W + WIN_W + REG_W + PH_W + HITS_W + 1;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		CFG_REUSE_THR   = 3'd0,
		CFG_STRIDE_LIM  = 3'd1,
		CFG_SPATIAL     = 3'd2,
		CFG_HITS_ON     = 3'd3,
		CFG_HITS_OFF    = 3'd4
	} cfg_idx_t;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [SET_W-1:0]  set_idx;
		logic [WAY_W-1:0]  way;
		logic [ADDR_W-1:0] addr;
		logic [PRED_W-1:0] pidx;
		logic              hit;
	} job_t;

	typedef struct packed {
		logic [ADDR_W-1:0] prev_addr;
		logic [TOT_W-1:0]  total;
		logic [WIN_W-1:0]  win;
		logic [REG_W-1:0]  regular;
		logic [PH_W-1:0]   phase_cnt;
		logic [HITS_W-1:0] hits;
		logic              prot;
	} meta_t;

	typedef struct packed {
		logic [1:0]  reuse_thr;
		logic [17:0] stride_lim;
		logic [3:0]  spatial;
		logic [6:0]  hits_on;
		logic [6:0]  hits_off;
	} cfg_t;

	function automatic logic [PRED_W-1:0] pred_hash(input logic [ADDR_W-1:0] pc);
		logic [ADDR_W-1:0] h;
		h = pc ^ (pc >> 2) ^ (pc >> 5);
		return h[PRED_W-1:0];
	endfunction

endpackage

// ===== design/rrip_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module rrip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/rrip_front.sv =====
// Front end: accepts input words, hashes the PC and queues jobs.
module rrip_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [10:0]               set_index,
	input  logic [3:0]                way_index,
	input  logic [47:0]               phys_addr,
	input  logic [47:0]               prog_counter,
	input  logic                      was_hit,
	output logic                      job_valid,
	output rrip_pkg::job_t            job,
	input  logic                      job_take
);
	rrip_pkg::job_t q_q [rrip_pkg::QDEPTH];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	rrip_pkg::job_t nj;

	always_comb begin
		nj.cmd     = cmd;
		nj.set_idx = set_index[rrip_pkg::SET_W-1:0];
		nj.way     = way_index;
		nj.addr    = phys_addr;
		nj.pidx    = rrip_pkg::pred_hash(prog_counter);
		nj.hit     = was_hit;
	end

	assign in_stall  = (cnt_q == 2'(rrip_pkg::QDEPTH));
	assign push      = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (job_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(job_take);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(rrip_pkg::QDEPTH)) else $error("queue overflow");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("take from empty queue");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> job_valid) else $error("stall while empty");
endmodule

// ===== design/rrip_back.sv =====
// Back end: sequencer that reads set state, runs the stride divide and writes back.
module rrip_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	input  rrip_pkg::job_t            job,
	output logic                      job_take,
	input  rrip_pkg::cfg_t            cfg,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                victim_way
);
	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_EVAL  = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_INS   = 8'b0010_0000,
		S_WB    = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	rrip_pkg::job_t j_q;
	logic [rrip_pkg::CLR_W-1:0] cl_q;

	// row memory: rrpv of all ways plus valid bits
	logic                            row_we;
	logic [rrip_pkg::SET_W-1:0]      row_wa, row_ra;
	logic [rrip_pkg::ROW_W+rrip_pkg::WAYS-1:0] row_wd, row_rd;
	logic                            meta_we;
	rrip_pkg::meta_t                 meta_wd, meta_rd;
	logic                            pred_we;
	logic [rrip_pkg::PRED_W-1:0]     pred_wa, pred_ra;
	logic [1:0]                      pred_wd, pred_rd;
	logic                            clearing;

	rrip_ram #(.WIDTH(rrip_pkg::ROW_W + rrip_pkg::WAYS), .DEPTH(rrip_pkg::SETS)) u_row (
		.clk(clk), .we(row_we), .waddr(row_wa), .wdata(row_wd),
		.raddr(row_ra), .rdata(row_rd));
	rrip_ram #(.WIDTH(rrip_pkg::META_W), .DEPTH(rrip_pkg::SETS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(row_wa), .wdata(meta_wd),
		.raddr(row_ra), .rdata(meta_rd));
	rrip_ram #(.WIDTH(2), .DEPTH(rrip_pkg::PRED_ENTRIES)) u_pred (
		.clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
		.raddr(pred_ra), .rdata(pred_rd));

	assign clearing = (state_q == S_CLEAR);
	assign row_ra   = job.set_idx;
	assign pred_ra  = job.pidx;

	// working registers
	logic [rrip_pkg::ROW_W-1:0] rr_q;
	logic [rrip_pkg::WAYS-1:0]  val_q;
	rrip_pkg::meta_t            m_q;
	logic [1:0]                 ctr_q;
	logic signed [rrip_pkg::STR_W-1:0] stride_q;
	logic                       do_avg_q;
	logic [3:0]                 vic_q;
	// divider
	logic [rrip_pkg::TOT_W-1:0] dq_q, drem_q;
	logic [rrip_pkg::WIN_W-1:0] dden_q;
	logic                       dneg_q;
	logic [4:0]                 dcnt_q;

	// victim search
	logic [3:0] inv_way, max_way, max_way1;
	logic       inv_any, max_any, max_any1;
	logic [1:0] age;
	always_comb begin
		inv_way = '0; inv_any = 1'b0;
		max_way = '0; max_any = 1'b0;
		max_way1 = '0; max_any1 = 1'b0;
		age = '0;
		for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
			if (!row_rd[rrip_pkg::ROW_W + w]) begin
				inv_way = 4'(w); inv_any = 1'b1;
			end
			if (row_rd[2*w +: 2] == rrip_pkg::RRPV_MAX) begin
				max_way = 4'(w); max_any = 1'b1;
			end
			if (row_rd[2*w +: 2] == 2'd2) begin
				max_way1 = 4'(w); max_any1 = 1'b1;
			end
		end
		if (max_any) age = 2'd0;
		else if (max_any1) age = 2'd1;
		else age = 2'd2;
	end

	// stride evaluation from the fetched meta
	logic signed [rrip_pkg::STR_W-1:0] stride_c, mag_c;
	logic signed [rrip_pkg::TOT_W-1:0] new_tot;
	logic counted;
	always_comb begin
		stride_c = rrip_pkg::STR_W'(j_q.addr) - rrip_pkg::STR_W'(meta_rd.prev_addr);
		mag_c    = stride_c < 0 ? -stride_c : stride_c;
		counted  = (stride_c != 0) && (mag_c < rrip_pkg::STR_W'(cfg.stride_lim));
		new_tot  = meta_rd.total + stride_c[rrip_pkg::TOT_W-1:0];
	end

	// predictor training
	logic [1:0] ctr_n;
	always_comb begin
		if (j_q.hit) ctr_n = (pred_rd == 2'd3) ? 2'd3 : pred_rd + 2'd1;
		else ctr_n = (pred_rd == 2'd0) ? 2'd0 : pred_rd - 2'd1;
	end

	// values taken at the end of the read cycle
	logic [rrip_pkg::ROW_W-1:0] rr_n;
	logic [3:0]                 vic_n;
	rrip_pkg::meta_t            m_n;
	logic                       avg_n;
	always_comb begin
		rr_n  = row_rd[rrip_pkg::ROW_W-1:0];
		vic_n = '0;
		m_n   = meta_rd;
		m_n.phase_cnt = meta_rd.phase_cnt + 1'b1;
		m_n.prev_addr = j_q.addr;
		avg_n = 1'b0;
		if (j_q.cmd == rrip_pkg::CMD_QUERY) begin
			// no way at 2 or 3: age twice and fall back to way 0
			if (inv_any) vic_n = inv_way;
			else if (max_any) vic_n = max_way;
			else if (max_any1) vic_n = max_way1;
			if (!inv_any)
				for (int w = 0; w < rrip_pkg::WAYS; w++)
					rr_n[2*w +: 2] = ({1'b0, row_rd[2*w +: 2]} + {1'b0, age} > 3'd3) ?
						rrip_pkg::RRPV_MAX : row_rd[2*w +: 2] + age;
		end else if (meta_rd.win < rrip_pkg::WIN_W'(rrip_pkg::STRIDE_WINDOW)) begin
			m_n.win = meta_rd.win + 1'b1;
			if (meta_rd.win != '0 && counted) begin
				m_n.total = new_tot;
				avg_n = (meta_rd.win > rrip_pkg::WIN_W'(1));
			end
		end else begin
			m_n.win     = rrip_pkg::WIN_W'(1);
			m_n.total   = '0;
			m_n.regular = '0;
		end
	end

	// divide step, restoring, magnitude
	logic [rrip_pkg::TOT_W:0] trial;
	assign trial = {drem_q, dq_q[rrip_pkg::TOT_W-1]} - (rrip_pkg::TOT_W+1)'(dden_q);

	logic signed [rrip_pkg::STR_W-1:0] avg_s, diff_s;
	logic spatial, near_c, way_ok;
	logic [1:0] ins;
	logic [8:0] lhs, rhs;
	logic [rrip_pkg::HITS_W-1:0] hits_now;
	logic [rrip_pkg::ROW_W-1:0]  rr_ins;
	logic [rrip_pkg::WAYS-1:0]   val_ins;
	rrip_pkg::meta_t             m_ins;
	always_comb begin
		avg_s  = dneg_q ? -rrip_pkg::STR_W'(dq_q) : rrip_pkg::STR_W'(dq_q);
		diff_s = stride_q - avg_s;
		near_c = (diff_s < rrip_pkg::STR_W'(rrip_pkg::LINE_SPAN)) &&
			(diff_s > -rrip_pkg::STR_W'(rrip_pkg::LINE_SPAN));
		lhs = 9'(m_q.regular) * 9'd10;
		rhs = 9'(cfg.spatial) * 9'(m_q.win - 1'b1);
		spatial = (m_q.win > rrip_pkg::WIN_W'(2)) && (lhs > rhs);
		if (ctr_q >= cfg.reuse_thr || spatial) ins = 2'd0;
		else if (m_q.prot) ins = 2'd1;
		else ins = rrip_pkg::RRPV_MAX;
		way_ok = (rrip_pkg::WAY_W+1)'(j_q.way) < (rrip_pkg::WAY_W+1)'(rrip_pkg::WAYS);
		rr_ins  = rr_q;
		val_ins = val_q;
		m_ins   = m_q;
		if (way_ok) begin
			rr_ins[2*j_q.way +: 2] = j_q.hit ? 2'd0 : ins;
			val_ins[j_q.way] = 1'b1;
		end
		hits_now = m_q.hits + rrip_pkg::HITS_W'(j_q.hit);
		if (m_q.phase_cnt == '0) begin
			if (hits_now >= cfg.hits_on) m_ins.prot = 1'b1;
			else if (hits_now < cfg.hits_off) m_ins.prot = 1'b0;
			m_ins.hits = '0;
		end else begin
			m_ins.hits = hits_now;
		end
	end

	always_comb begin
		row_we  = 1'b0; meta_we = 1'b0; pred_we = 1'b0;
		row_wa  = j_q.set_idx; pred_wa = j_q.pidx;
		row_wd  = {val_q, rr_q};
		meta_wd = m_q; pred_wd = ctr_q;
		if (clearing) begin
			row_we  = 1'b1; meta_we = 1'b1; pred_we = 1'b1;
			row_wa  = cl_q[rrip_pkg::SET_W-1:0];
			pred_wa = cl_q[rrip_pkg::PRED_W-1:0];
			row_wd  = {{rrip_pkg::WAYS{1'b0}}, {rrip_pkg::WAYS{rrip_pkg::RRPV_MAX}}};
			meta_wd = '0; meta_wd.prot = 1'b1;
			pred_wd = 2'd1;
		end else if (state_q == S_WB) begin
			row_we = 1'b1; meta_we = j_q.cmd; pred_we = j_q.cmd;
		end
	end

	assign job_take  = (state_q == S_IDLE) && job_valid;
	assign out_valid = (state_q == S_OUT);
	assign victim_way = vic_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (job_valid) j_q <= job;
			S_READ: begin
				rr_q     <= rr_n;
				val_q    <= row_rd[rrip_pkg::ROW_W +: rrip_pkg::WAYS];
				ctr_q    <= ctr_n;
				m_q      <= m_n;
				do_avg_q <= avg_n;
				stride_q <= stride_c;
				vic_q    <= vic_n;
				dneg_q   <= new_tot[rrip_pkg::TOT_W-1];
				dq_q     <= new_tot[rrip_pkg::TOT_W-1] ? -new_tot : new_tot;
				dden_q   <= meta_rd.win - 1'b1;
				drem_q   <= '0;
				dcnt_q   <= '0;
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (!trial[rrip_pkg::TOT_W]) begin
					drem_q <= trial[rrip_pkg::TOT_W-1:0];
					dq_q   <= {dq_q[rrip_pkg::TOT_W-2:0], 1'b1};
				end else begin
					drem_q <= {drem_q[rrip_pkg::TOT_W-2:0], dq_q[rrip_pkg::TOT_W-1]};
					dq_q   <= {dq_q[rrip_pkg::TOT_W-2:0], 1'b0};
				end
			end
			S_EVAL: if (do_avg_q && near_c) m_q.regular <= m_q.regular + 1'b1;
			S_INS: begin
				rr_q  <= rr_ins;
				val_q <= val_ins;
				m_q   <= m_ins;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cl_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cl_q <= cl_q + 1'b1;
					if (cl_q == rrip_pkg::CLR_W'(rrip_pkg::CLR_N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (job_valid) state_q <= S_READ;
				S_READ: state_q <= (j_q.cmd == rrip_pkg::CMD_UPDATE) ? S_DIV : S_WB;
				S_DIV: if (!do_avg_q || dcnt_q == 5'(rrip_pkg::TOT_W - 1)) state_q <= S_EVAL;
				S_EVAL: state_q <= S_INS;
				S_INS: state_q <= S_WB;
				S_WB: state_q <= j_q.cmd ? S_IDLE : S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (j_q.cmd == rrip_pkg::CMD_QUERY)) else $error("result from update");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> (state_q == S_READ)) else $error("job lost");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(victim_way)))
		else $error("result dropped");
endmodule

// ===== design/rrip_cfg.sv =====
// Configuration register file.
module rrip_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [17:0]    cfg_data,
	output rrip_pkg::cfg_t cfg
);
	rrip_pkg::cfg_t cfg_q;
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reuse_thr  <= 2'd2;
			cfg_q.stride_lim <= 18'd131072;
			cfg_q.spatial    <= 4'd7;
			cfg_q.hits_on    <= 7'd25;
			cfg_q.hits_off   <= 7'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rrip_pkg::CFG_REUSE_THR:  cfg_q.reuse_thr  <= cfg_data[1:0];
				rrip_pkg::CFG_STRIDE_LIM: cfg_q.stride_lim <= cfg_data;
				rrip_pkg::CFG_SPATIAL:    cfg_q.spatial    <= cfg_data[3:0];
				rrip_pkg::CFG_HITS_ON:    cfg_q.hits_on    <= cfg_data[6:0];
				rrip_pkg::CFG_HITS_OFF:   cfg_q.hits_off   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end
endmodule

// ===== design/rrip_replacement_with_reuse_predictor.sv =====
// Top level of the RRIP replacement policy with PC reuse predictor.
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | cmd set_index way_index phys_addr prog_counter was_hit
// out     | out | out_valid/out_stall| victim_way
// cfg     | in  | cfg_valid/cfg_ready| cfg_index cfg_data
// A query holds the back end for take, read, write back and the stallable result word.
// A counted stride in an update runs the 24-step average divider.
// After reset a clearing pass initialises the set and predictor memories.
// A two-word queue lets inputs be taken while the back end works or its result stalls.
module rrip_replacement_with_reuse_predictor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic [47:0] phys_addr,
	input  logic [47:0] prog_counter,
	input  logic        was_hit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  victim_way,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	logic           job_valid, job_take;
	rrip_pkg::job_t job;
	rrip_pkg::cfg_t cfg;

	rrip_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg));

	rrip_front u_front (.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_stall(in_stall), .cmd(cmd), .set_index(set_index), .way_index(way_index),
		.phys_addr(phys_addr), .prog_counter(prog_counter), .was_hit(was_hit),
		.job_valid(job_valid), .job(job), .job_take(job_take));

	rrip_back u_back (.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .cfg(cfg), .out_valid(out_valid), .out_stall(out_stall),
		.victim_way(victim_way));
endmodule

// ===== tb/rrip_replacement_with_reuse_predictor_tb.sv =====
// Self-checking testbench of the RRIP replacement block with PC reuse predictor.
`timescale 1ns / 100ps

module rrip_replacement_with_reuse_predictor_tb;

	localparam int IDLE_WAIT = 200;
	localparam int STALL_LIMIT = 40000;
	localparam logic [2:0] UNUSED_IDX = 3'd7;

	// Predictor of the replacement policy and store of expected victims.
	class victim_scoreboard;
		logic [1:0]  rrpv_m [rrip_pkg::SETS*rrip_pkg::WAYS];
		logic        valid_m [rrip_pkg::SETS*rrip_pkg::WAYS];
		logic [47:0] prev_m [rrip_pkg::SETS];
		longint      total_m [rrip_pkg::SETS];
		int          win_m [rrip_pkg::SETS];
		int          reg_m [rrip_pkg::SETS];
		int          phcnt_m [rrip_pkg::SETS];
		int          hits_m [rrip_pkg::SETS];
		logic        prot_m [rrip_pkg::SETS];
		logic [1:0]  reuse_m [rrip_pkg::PRED_ENTRIES];
		rrip_pkg::cfg_t cfg;
		logic [3:0]  victims_q[$];
		int          mismatches;
		int          queries;
		int          updates;

		function new();
			foreach (rrpv_m[i]) begin
				rrpv_m[i] = rrip_pkg::RRPV_MAX;
				valid_m[i] = 1'b0;
			end
			foreach (prev_m[s]) begin
				prev_m[s] = '0;
				total_m[s] = 0;
				win_m[s] = 0;
				reg_m[s] = 0;
				phcnt_m[s] = 0;
				hits_m[s] = 0;
				prot_m[s] = 1'b1;
			end
			foreach (reuse_m[i])
				reuse_m[i] = 2'd1;
			cfg.reuse_thr = 2'd2;
			cfg.stride_lim = 18'd131072;
			cfg.spatial = 4'd7;
			cfg.hits_on = 7'd25;
			cfg.hits_off = 7'd10;
			mismatches = 0;
			queries = 0;
			updates = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [17:0] data);
			unique case (idx)
				rrip_pkg::CFG_REUSE_THR:  cfg.reuse_thr = data[1:0];
				rrip_pkg::CFG_STRIDE_LIM: cfg.stride_lim = data;
				rrip_pkg::CFG_SPATIAL:    cfg.spatial = data[3:0];
				rrip_pkg::CFG_HITS_ON:    cfg.hits_on = data[6:0];
				rrip_pkg::CFG_HITS_OFF:   cfg.hits_off = data[6:0];
				default: ;
			endcase
		endfunction

		function logic [3:0] choose_victim(int s);
			int b;
			b = s * rrip_pkg::WAYS;
			for (int w = 0; w < rrip_pkg::WAYS; w++)
				if (!valid_m[b+w])
					return w[3:0];
			for (int r = 0; r < 2; r++) begin
				for (int w = 0; w < rrip_pkg::WAYS; w++)
					if (rrpv_m[b+w] == rrip_pkg::RRPV_MAX)
						return w[3:0];
				for (int w = 0; w < rrip_pkg::WAYS; w++)
					if (rrpv_m[b+w] != rrip_pkg::RRPV_MAX)
						rrpv_m[b+w]++;
			end
			return 4'd0;
		endfunction

		function void note_input(logic c, logic [10:0] si, logic [3:0] wi,
				logic [47:0] addr, logic [47:0] pc, logic hit);
			int s, slot, pi;
			longint stride, avg, d;
			logic [47:0] h;
			logic [1:0] ins;
			logic spatial;
			s = int'(si);
			if (c == rrip_pkg::CMD_QUERY) begin
				victims_q.push_back(choose_victim(s));
				queries++;
				return;
			end
			updates++;
			h = pc ^ (pc >> 2) ^ (pc >> 5);
			pi = int'(h % rrip_pkg::PRED_ENTRIES);
			slot = s * rrip_pkg::WAYS + int'(wi);
			phcnt_m[s] = (phcnt_m[s] + 1) % rrip_pkg::PHASE_LEN;
			if (hit) begin
				if (reuse_m[pi] != 2'd3) reuse_m[pi]++;
			end else if (reuse_m[pi] != 2'd0)
				reuse_m[pi]--;
			// stride window
			if (win_m[s] < rrip_pkg::STRIDE_WINDOW) begin
				if (win_m[s] > 0) begin
					stride = longint'({16'd0, addr}) - longint'({16'd0, prev_m[s]});
					d = stride < 0 ? -stride : stride;
					if (stride != 0 && d < longint'(cfg.stride_lim)) begin
						total_m[s] += stride;
						if (win_m[s] > 1) begin
							avg = total_m[s] / longint'(win_m[s] - 1);
							d = stride - avg;
							if (d < 0) d = -d;
							if (d < rrip_pkg::LINE_SPAN) reg_m[s]++;
						end
					end
				end
				win_m[s]++;
			end else begin
				total_m[s] = 0;
				win_m[s] = 1;
				reg_m[s] = 0;
			end
			prev_m[s] = addr;
			if (hit) begin
				hits_m[s]++;
				rrpv_m[slot] = 2'd0;
				valid_m[slot] = 1'b1;
			end else begin
				spatial = 1'b0;
				if (win_m[s] > 2)
					spatial = reg_m[s] * 10 > int'(cfg.spatial) * (win_m[s] - 1);
				if (reuse_m[pi] >= cfg.reuse_thr || spatial) ins = 2'd0;
				else if (prot_m[s]) ins = 2'd1;
				else ins = rrip_pkg::RRPV_MAX;
				rrpv_m[slot] = ins;
				valid_m[slot] = 1'b1;
			end
			if (phcnt_m[s] == 0) begin
				if (hits_m[s] >= int'(cfg.hits_on)) prot_m[s] = 1'b1;
				else if (hits_m[s] < int'(cfg.hits_off)) prot_m[s] = 1'b0;
				hits_m[s] = 0;
			end
		endfunction

		function void check_victim(logic [3:0] got);
			logic [3:0] exp_way;
			if (victims_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected victim word: victim_way=%0d", got);
				return;
			end
			exp_way = victims_q.pop_front();
			if (got !== exp_way) begin
				mismatches++;
				if (mismatches <= 10)
					$display("victim_way mismatch: expected %0d, got %0d", exp_way, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [10:0] set_index;
	logic [3:0]  way_index;
	logic [47:0] phys_addr;
	logic [47:0] prog_counter;
	logic        was_hit;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  victim_way;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_data;

	victim_scoreboard sb;
	int idle_cycles;
	bit stim_done;
	bit long_stall;

	rrip_replacement_with_reuse_predictor i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .set_index(set_index), .way_index(way_index),
		.phys_addr(phys_addr), .prog_counter(prog_counter), .was_hit(was_hit),
		.out_valid(out_valid), .out_stall(out_stall), .victim_way(victim_way),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver side: random stall, check every accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_victim(victim_way);
			if (long_stall)
				out_stall <= ($urandom_range(0, 99) < 60);
			else
				out_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("[rrip_replacement_with_reuse_predictor] ERROR");
			$finish;
		end
	end

	// Valid stays high between back-to-back words; drop it only for a gap.
	task automatic send_word(logic c, logic [10:0] s, logic [3:0] w,
			logic [47:0] a, logic [47:0] pc, logic h);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		set_index <= s;
		way_index <= w;
		phys_addr <= a;
		prog_counter <= pc;
		was_hit <= h;
		do @(posedge clk); while (in_stall);
		sb.note_input(c, s, w, a, pc, h);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.victims_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [17:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic write_all(logic [1:0] thr, logic [17:0] lim, logic [3:0] sp,
			logic [6:0] hi, logic [6:0] lo);
		drain();
		write_reg(rrip_pkg::CFG_REUSE_THR, 18'(thr));
		write_reg(rrip_pkg::CFG_STRIDE_LIM, lim);
		write_reg(rrip_pkg::CFG_SPATIAL, 18'(sp));
		write_reg(rrip_pkg::CFG_HITS_ON, 18'(hi));
		write_reg(rrip_pkg::CFG_HITS_OFF, 18'(lo));
		write_reg(UNUSED_IDX, 18'h3ffff);
		cfg_valid <= 1'b0;
	endtask

	// Random phase: mostly strided streams on a few sets, with noise.
	task automatic random_phase(int n);
		logic [10:0] s;
		logic [47:0] a, pc;
		logic [47:0] step;
		for (int i = 0; i < n; i++) begin
			s = 11'($urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0) s = 11'($urandom_range(0, 2047));
			pc = 48'({$urandom_range(0, 31), 2'b00});
			if ($urandom_range(0, 19) == 0) pc = 48'({$urandom, $urandom});
			step = 48'd64 * 48'($urandom_range(1, 3));
			a = 48'({s, 6'd0}) * 48'd4096 + step * 48'(i);
			if ($urandom_range(0, 7) == 0) a = 48'({$urandom, $urandom});
			if ($urandom_range(0, 9) == 0)
				a = 48'hffff_ffff_ffff - 48'($urandom_range(0, 300));
			if ($urandom_range(0, 3) == 0)
				send_word(rrip_pkg::CMD_QUERY, s, 4'($urandom), 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}), 1'($urandom));
			else
				send_word(rrip_pkg::CMD_UPDATE, s, 4'($urandom), a, pc,
					$urandom_range(0, 2) == 0);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = rrip_pkg::CMD_QUERY;
		set_index = '0;
		way_index = '0;
		phys_addr = '0;
		prog_counter = '0;
		was_hit = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rrip_pkg::CFG_REUSE_THR;
		cfg_data = '0;
		stim_done = 1'b0;
		long_stall = 1'b0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: invalid fill order, extremes, highest way index, full aging.
		send_word(rrip_pkg::CMD_QUERY, 11'd0, 4'd0, '0, '0, 1'b0);
		send_word(rrip_pkg::CMD_QUERY, 11'd2047, 4'd15, '1, '1, 1'b1);
		for (int w = 0; w < rrip_pkg::WAYS; w++)
			send_word(rrip_pkg::CMD_UPDATE, 11'd5, 4'(w), 48'd64 * 48'(w), 48'd0, (w < 4));
		send_word(rrip_pkg::CMD_QUERY, 11'd5, 4'd0, '0, '0, 1'b0);
		send_word(rrip_pkg::CMD_UPDATE, 11'd2047, 4'd15, 48'hffff_ffff_ffff,
			48'hffff_ffff_ffff, 1'b1);
		send_word(rrip_pkg::CMD_UPDATE, 11'd2047, 4'd3, 48'd0, 48'hffff_ffff_ffff, 1'b0);
		send_word(rrip_pkg::CMD_QUERY, 11'd5, 4'd0, '0, '0, 1'b0);
		send_word(rrip_pkg::CMD_QUERY, 11'd5, 4'd0, '0, '0, 1'b0);

		random_phase(500);
		write_all(2'd0, 18'd1, 4'd0, 7'd0, 7'd0);
		random_phase(350);
		// Hold off the sender with a stalling receiver until all victims are back.
		long_stall = 1'b1;
		random_phase(100);
		drain();
		long_stall = 1'b0;
		write_all(2'd3, 18'h3ffff, 4'd10, 7'd64, 7'd64);
		random_phase(500);
		write_all(2'd1, 18'd300, 4'd3, 7'd5, 7'd2);
		random_phase(500);

		drain();
		stim_done = 1'b1;
		$display("covered %0d victim queries and %0d updates over four register settings",
			sb.queries, sb.updates);
		if (sb.mismatches == 0 && sb.victims_q.size() == 0)
			$display("[rrip_replacement_with_reuse_predictor] OK");
		else
			$display("[rrip_replacement_with_reuse_predictor] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/rrip_pkg.sv
design/rrip_ram.sv
design/rrip_front.sv
design/rrip_back.sv
design/rrip_cfg.sv
design/rrip_replacement_with_reuse_predictor.sv
tb/rrip_replacement_with_reuse_predictor_tb.sv
